// File: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants for the square tone generator with sweep
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int unsigned RateW  = 18;
	localparam int unsigned ToneW  = 11;
	localparam int unsigned LenW   = 12;
	localparam int unsigned SweepW = 14;
	localparam int unsigned AccW   = 31;
	localparam int unsigned MulStepsP = 12;
	localparam int unsigned MulStepsS = 3;

	localparam logic [ToneW-1:0] ToneMax = 11'd2047;
	localparam logic [LenW-1:0]  LenMax  = 12'd4095;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SAMPLE_RATE     = 3'd0,
		REG_START_FREQUENCY = 3'd1,
		REG_DUTY_SELECT     = 3'd2,
		REG_SWEEP_ENABLE    = 3'd3,
		REG_SWEEP_TIME      = 3'd4,
		REG_SWEEP_DIRECTION = 3'd5,
		REG_SWEEP_SHIFT     = 3'd6
	} reg_index_t;

	// duty codes
	typedef enum logic [1:0] {
		DUTY_12 = 2'd0,
		DUTY_25 = 2'd1,
		DUTY_50 = 2'd2,
		DUTY_75 = 2'd3
	} duty_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MULP = 5'b00010,
		ST_LENS = 5'b00100,
		ST_MULS = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

endpackage

// File: hdl/square_tone_with_sweep.sv
// ----------------------------------------------------------------------------
// square_tone_with_sweep
// square wave level generator, one level per sample tick, with frequency sweep
// ----------------------------------------------------------------------------
//
//  channel  | beat fields (lowest bit first)               | role
//  ---------+----------------------------------------------+------------------
//  s_axis   | tdata: restart ; tlast: block_end            | one sample tick
//  m_axis   | tdata: level_high, active ; tlast: blk end   | one level out
//  cfg      | cfg_index selects register, cfg_data value   | write only
//
//  each tick runs through these steps in order: one to take the beat, 12
//  shift-add multiplier steps for the period product, one for length
//  rounding, 3 steps for the sweep interval and one for the counter
//  update, which waits while the output is stalled
//  the next tick is taken as soon as the result sits in the output register
//  async reset loads the documented register defaults and clears all counters
//  a stalled output holds the finished level and only blocks the update cycle
//
module square_tone_with_sweep
	import sts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// slave side
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [0] restart, rest zero
	input  logic                s_tlast,   // block_end
	// master side
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [0] level_high, [1] active, rest zero
	output logic                m_tlast,   // block_end_out
	// config write port
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [RateW-1:0]    cfg_data
);

	// configuration registers
	logic [RateW-1:0] sample_rate_q;
	logic [ToneW-1:0] start_freq_q;
	logic [1:0]       duty_q;
	logic             sweep_en_q;
	logic [2:0]       sweep_time_q;
	logic             sweep_dir_q;
	logic [2:0]       sweep_shift_q;

	// channel state
	logic [ToneW-1:0]  tone_q;
	logic [LenW-1:0]   phase_q;
	logic [LenW-1:0]   period_q;
	logic [LenW-1:0]   high_q;
	logic [SweepW-1:0] sweep_cnt_q;
	logic              stopped_q;

	// sequencer and multiplier
	state_t            state_q;
	logic [3:0]        step_q;
	logic [AccW-1:0]   acc_q;
	logic              blk_q;

	// output register
	logic              out_valid_q;
	logic              level_q;
	logic              active_q;
	logic              last_q;

	// multiplier step: add sample rate when the low multiplier bit is set, shift right
	logic [18:0]       mul_sum;
	logic [AccW-1:0]   acc_step;

	// length rounding
	logic [30:0]       psum;
	logic [13:0]       pq;
	logic [LenW-1:0]   period_calc;
	logic [14:0]       high_prod;
	logic [14:0]       high_sum;

	// sweep interval rounding
	logic [21:0]       isum;
	logic [SweepW-1:0] interval;

	// update
	logic              upd_fire;
	logic [LenW:0]     phase_next;
	logic [SweepW:0]   sweep_next;
	logic [ToneW-1:0]  delta;
	logic [ToneW:0]    tone_add;
	logic              in_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || m_tready);

	assign mul_sum  = acc_q[30:12] + (acc_q[0] ? {1'b0, sample_rate_q} : 19'd0);
	assign acc_step = {1'b0, mul_sum, acc_q[11:1]};

	// period: round half up of the product over 2^17, saturated to 12 bits
	assign psum        = {1'b0, acc_q[29:0]} + 31'd65536;
	assign pq          = psum[30:17];
	assign period_calc = (pq > {2'b00, LenMax}) ? LenMax : pq[LenW-1:0];

	always_comb begin
		case (duty_q)
			DUTY_12: high_prod = {3'b000, period_calc};
			DUTY_25: high_prod = {2'b00, period_calc, 1'b0};
			DUTY_50: high_prod = {1'b0, period_calc, 2'b00};
			DUTY_75: high_prod = {1'b0, period_calc, 2'b00} + {2'b00, period_calc, 1'b0};
			default: high_prod = {3'b000, period_calc};
		endcase
	end
	assign high_sum = high_prod + 15'd4;

	// after three steps the sweep product sits nine bits up
	assign isum     = acc_q[30:9] + 22'd64;
	assign interval = isum[20:7];

	assign phase_next = {1'b0, phase_q} + 13'd1;
	assign sweep_next = {1'b0, sweep_cnt_q} + 15'd1;
	assign delta      = tone_q >> sweep_shift_q;
	assign tone_add   = {1'b0, tone_q} + {1'b0, delta};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= 18'd48000;
			start_freq_q  <= '0;
			duty_q        <= DUTY_50;
			sweep_en_q    <= 1'b0;
			sweep_time_q  <= '0;
			sweep_dir_q   <= 1'b0;
			sweep_shift_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE:     sample_rate_q <= cfg_data;
				REG_START_FREQUENCY: start_freq_q  <= cfg_data[ToneW-1:0];
				REG_DUTY_SELECT:     duty_q        <= cfg_data[1:0];
				REG_SWEEP_ENABLE:    sweep_en_q    <= cfg_data[0];
				REG_SWEEP_TIME:      sweep_time_q  <= cfg_data[2:0];
				REG_SWEEP_DIRECTION: sweep_dir_q   <= cfg_data[0];
				REG_SWEEP_SHIFT:     sweep_shift_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer, channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			acc_q       <= '0;
			tone_q      <= '0;
			phase_q     <= '0;
			sweep_cnt_q <= '0;
			stopped_q   <= 1'b0;
			period_q    <= 12'd750;
			high_q      <= 12'd375;
			out_valid_q <= 1'b0;
			level_q     <= 1'b0;
			active_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// a new level loads the output register, a taken beat empties it
			if (upd_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// restart happens before this tick
						if (s_tdata[0]) begin
							tone_q      <= start_freq_q;
							phase_q     <= '0;
							sweep_cnt_q <= '0;
							stopped_q   <= 1'b0;
							acc_q       <= {19'd0, 12'd2048 - {1'b0, start_freq_q}};
						end else begin
							acc_q       <= {19'd0, 12'd2048 - {1'b0, tone_q}};
						end
						step_q  <= '0;
						state_q <= ST_MULP;
					end
				end
				ST_MULP: begin
					acc_q  <= acc_step;
					step_q <= step_q + 4'd1;
					if (step_q == 4'(MulStepsP - 1))
						state_q <= ST_LENS;
				end
				ST_LENS: begin
					period_q <= period_calc;
					high_q   <= high_sum[14:3];
					acc_q    <= {28'd0, sweep_time_q};
					step_q   <= '0;
					state_q  <= ST_MULS;
				end
				ST_MULS: begin
					acc_q  <= acc_step;
					step_q <= step_q + 4'd1;
					if (step_q == 4'(MulStepsS - 1))
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q     <= ST_IDLE;
						if (stopped_q) begin
							level_q  <= 1'b0;
							active_q <= 1'b0;
						end else begin
							level_q  <= (phase_q < high_q);
							active_q <= 1'b1;
							if (phase_next >= {1'b0, period_q})
								phase_q <= '0;
							else
								phase_q <= phase_next[LenW-1:0];
							if (sweep_en_q && (sweep_time_q != 3'd0)) begin
								if (sweep_next >= {1'b0, interval}) begin
									sweep_cnt_q <= '0;
									if (sweep_shift_q != 3'd0) begin
										if (sweep_dir_q)
											tone_q <= tone_q - delta;
										else if (tone_add > {1'b0, ToneMax})
											stopped_q <= 1'b1;
										else
											tone_q <= tone_add[ToneW-1:0];
									end
								end else begin
									sweep_cnt_q <= sweep_next[SweepW-1:0];
								end
							end
						end
						last_q <= blk_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// block end rides along with the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			blk_q <= 1'b0;
		else if (in_fire)
			blk_q <= s_tlast;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, active_q, level_q};
	assign m_tlast  = last_q;

endmodule
